// ===== rtl/core/two_lane_split_race_timer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Race timer assertion macros
// Shared concurrent assertion wrappers for the race timer checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LANE_SPLIT_RACE_TIMER_CORE_ASSERT_SVH
`define TWO_LANE_SPLIT_RACE_TIMER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TRT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/trt_pkg.sv =====
// ----------------------------------------------------------------------------
// Race timer package
// Item types, control state and codes shared by the race timer modules.
// ----------------------------------------------------------------------------
package trt_pkg;

    localparam int OUT_TIME_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register index, taken from paddr[2]
    localparam logic CFG_IDX_LANE_SWAP = 1'b0;
    localparam logic LANE_SWAP_RESET   = 1'b1;

    // Button bit codes
    localparam logic [2:0] BTN_NONE  = 3'b000;
    localparam logic [2:0] BTN_START = 3'b001;
    localparam logic [2:0] BTN_STOP  = 3'b010;
    localparam logic [2:0] BTN_RESET = 3'b100;

    localparam logic [1:0] TGT_ZERO = 2'b01;
    localparam logic [1:0] TGT_ONE  = 2'b10;
    localparam logic [1:0] TGT_BOTH = 2'b11;
    localparam logic [1:0] TGT_NONE = 2'b00;

    typedef struct packed {
        logic tick;
        logic start_level;
        logic stop_level;
        logic reset_level;
        logic target_zero_level;
        logic target_one_level;
    } in_item_t;

    typedef struct packed {
        logic                  is_running;
        logic [OUT_TIME_W-1:0] elapsed;
        logic [OUT_TIME_W-1:0] left_lane_time;
        logic [OUT_TIME_W-1:0] right_lane_time;
        logic                  left_finished;
        logic                  right_finished;
    } out_item_t;

    // Control state carried between the state registers and the step logic
    typedef struct packed {
        logic       running;
        logic       left_done;
        logic       right_done;
        logic [1:0] armed;
        logic [2:0] prev_buttons;
        logic [1:0] prev_targets;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        running:      1'b0,
        left_done:    1'b0,
        right_done:   1'b0,
        armed:        TGT_BOTH,
        prev_buttons: BTN_NONE,
        prev_targets: TGT_BOTH
    };

endpackage

// ===== rtl/core/trt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Race timer configuration registers
// APB-style register file holding the lane swap setting.
// ----------------------------------------------------------------------------
module trt_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [trt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [trt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [trt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic                             lane_swap
);

    logic lane_swap_reg;
    logic lane_swap_next;
    logic wr_en;
    logic reg_idx;

    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        lane_swap_next = lane_swap_reg;
        if (wr_en && (reg_idx == trt_pkg::CFG_IDX_LANE_SWAP))
        begin
            lane_swap_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_swap_reg <= trt_pkg::LANE_SWAP_RESET;
        end
        else
        begin
            lane_swap_reg <= lane_swap_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == trt_pkg::CFG_IDX_LANE_SWAP)
        begin
            prdata = {{(trt_pkg::CFG_DATA_W-1){1'b0}}, lane_swap_reg};
        end
    end

    assign lane_swap = lane_swap_reg;

endmodule

// ===== rtl/core/trt_step.sv =====
// ----------------------------------------------------------------------------
// Race timer step logic
// Next-state logic for one sample: buttons, target hits, then the tick.
// ----------------------------------------------------------------------------
module trt_step #(
    parameter int TIME_BITS = 32
) (
    input  trt_pkg::in_item_t       item,
    input  logic                    lane_swap,
    input  trt_pkg::ctrl_t          cur_ctrl,
    input  logic [TIME_BITS-1:0]    cur_count,
    input  logic [TIME_BITS-1:0]    cur_left,
    input  logic [TIME_BITS-1:0]    cur_right,
    output trt_pkg::ctrl_t          nxt_ctrl,
    output logic [TIME_BITS-1:0]    nxt_count,
    output logic [TIME_BITS-1:0]    nxt_left,
    output logic [TIME_BITS-1:0]    nxt_right
);

    logic [2:0] buttons;
    logic [1:0] targets;
    logic [2:0] watch;
    logic [2:0] rise;
    logic [1:0] fall;

    assign buttons = {item.reset_level, item.stop_level, item.start_level};
    assign targets = {item.target_one_level, item.target_zero_level};
    assign watch   = cur_ctrl.running ? trt_pkg::BTN_STOP
                                      : (trt_pkg::BTN_START | trt_pkg::BTN_RESET);
    assign rise    = buttons & ~cur_ctrl.prev_buttons & watch;
    assign fall    = cur_ctrl.prev_targets & ~targets;

    always_comb
    begin
        nxt_ctrl  = cur_ctrl;
        nxt_count = cur_count;
        nxt_left  = cur_left;
        nxt_right = cur_right;

        // Only a single watched button edge acts
        if (rise == trt_pkg::BTN_START)
        begin
            nxt_ctrl.running = 1'b1;
        end
        else if (rise == trt_pkg::BTN_STOP)
        begin
            nxt_ctrl.running = 1'b0;
        end
        else if ((rise == trt_pkg::BTN_RESET) && (targets == trt_pkg::TGT_BOTH))
        begin
            nxt_ctrl.armed      = trt_pkg::TGT_BOTH;
            nxt_ctrl.left_done  = 1'b0;
            nxt_ctrl.right_done = 1'b0;
            nxt_ctrl.running    = 1'b0;
            nxt_count           = '0;
            nxt_left            = '0;
            nxt_right           = '0;
        end

        // Target zero goes first; it may stop timing before target one is seen
        if (nxt_ctrl.running && fall[0] && nxt_ctrl.armed[0])
        begin
            nxt_ctrl.armed = nxt_ctrl.armed & ~trt_pkg::TGT_ZERO;
            if (lane_swap)
            begin
                nxt_right           = nxt_count;
                nxt_ctrl.right_done = 1'b1;
            end
            else
            begin
                nxt_left           = nxt_count;
                nxt_ctrl.left_done = 1'b1;
            end
            if (nxt_ctrl.armed == trt_pkg::TGT_NONE)
            begin
                nxt_ctrl.running = 1'b0;
            end
        end

        if (nxt_ctrl.running && fall[1] && nxt_ctrl.armed[1])
        begin
            nxt_ctrl.armed = nxt_ctrl.armed & ~trt_pkg::TGT_ONE;
            if (lane_swap)
            begin
                nxt_left           = nxt_count;
                nxt_ctrl.left_done = 1'b1;
            end
            else
            begin
                nxt_right           = nxt_count;
                nxt_ctrl.right_done = 1'b1;
            end
            if (nxt_ctrl.armed == trt_pkg::TGT_NONE)
            begin
                nxt_ctrl.running = 1'b0;
            end
        end

        // Advance the race clock; wraps at TIME_BITS
        if (nxt_ctrl.running && item.tick)
        begin
            nxt_count = nxt_count + {{(TIME_BITS-1){1'b0}}, 1'b1};
        end

        nxt_ctrl.prev_buttons = buttons;
        nxt_ctrl.prev_targets = targets;
    end

endmodule

// ===== rtl/core/two_lane_split_race_timer_core.sv =====
// ----------------------------------------------------------------------------
// Two-lane race timer core
// Stopwatch with two target inputs that capture split times per lane.
// ----------------------------------------------------------------------------
//
// Channel   Signals                          Moves
// --------  -------------------------------  ---------------------------------
// in        in_valid / in_ready / in_data    one pin sample item per cycle
// out       out_valid / out_ready / out_data one status item per input item
// cfg       psel penable pwrite paddr ...    lane_swap register at address 0
//
// One item per cycle sustained while out_ready stays high. An accepted item
// lands in the input register and passes the step logic into the state and
// result registers once the result register is free or draining. While the
// result register waits on out_ready, the input register can still take one item.
// Reset clears all timing state, arms both targets and sets lane_swap to 1.
// A stall at the output holds the result and, one item later, the input.
// ----------------------------------------------------------------------------
module two_lane_split_race_timer_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  trt_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output trt_pkg::out_item_t               out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [trt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [trt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [trt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int OW = trt_pkg::OUT_TIME_W;

    logic                   lane_swap;

    // Input stage
    logic                   in_valid_reg;
    logic                   in_valid_next;
    trt_pkg::in_item_t      in_item_reg;

    // Timer state
    trt_pkg::ctrl_t         ctrl_reg;
    trt_pkg::ctrl_t         ctrl_next;
    logic [TIME_BITS-1:0]   count_reg;
    logic [TIME_BITS-1:0]   count_next;
    logic [TIME_BITS-1:0]   left_reg;
    logic [TIME_BITS-1:0]   left_next;
    logic [TIME_BITS-1:0]   right_reg;
    logic [TIME_BITS-1:0]   right_next;

    // Result stage
    logic                   out_valid_reg;
    logic                   out_valid_next;
    trt_pkg::out_item_t     out_item_reg;
    trt_pkg::out_item_t     out_item_next;

    logic                   in_accept;
    logic                   advance;

    // Times are widened then cut, so any TIME_BITS maps onto 32 output bits
    logic [TIME_BITS+OW-1:0] count_ext;
    logic [TIME_BITS+OW-1:0] left_ext;
    logic [TIME_BITS+OW-1:0] right_ext;

    trt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .lane_swap (lane_swap)
    );

    trt_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .item      (in_item_reg),
        .lane_swap (lane_swap),
        .cur_ctrl  (ctrl_reg),
        .cur_count (count_reg),
        .cur_left  (left_reg),
        .cur_right (right_reg),
        .nxt_ctrl  (ctrl_next),
        .nxt_count (count_next),
        .nxt_left  (left_next),
        .nxt_right (right_next)
    );

    // Advance the held item whenever the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign count_ext = {{OW{1'b0}}, count_next};
    assign left_ext  = {{OW{1'b0}}, left_next};
    assign right_ext = {{OW{1'b0}}, right_next};

    // Result reflects the state after the step
    always_comb
    begin
        out_item_next.is_running      = ctrl_next.running;
        out_item_next.elapsed         = count_ext[OW-1:0];
        out_item_next.left_lane_time  = left_ext[OW-1:0];
        out_item_next.right_lane_time = right_ext[OW-1:0];
        out_item_next.left_finished   = ctrl_next.left_done;
        out_item_next.right_finished  = ctrl_next.right_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= trt_pkg::CTRL_RESET;
            count_reg     <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // Commit state only when an item actually passes the step logic
            if (advance)
            begin
                ctrl_reg  <= ctrl_next;
                count_reg <= count_next;
                left_reg  <= left_next;
                right_reg <= right_next;
            end
        end
    end

    // Payload registers: load on handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// ===== rtl/core/trt_checker.sv =====
// ----------------------------------------------------------------------------
// Race timer port checker
// Concurrent checks on the race timer ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_lane_split_race_timer_core_assert.svh"

module trt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input trt_pkg::in_item_t                in_data,
    input logic                             out_valid,
    input logic                             out_ready,
    input trt_pkg::out_item_t               out_data,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [trt_pkg::CFG_ADDR_W-1:0]   paddr,
    input logic [trt_pkg::CFG_DATA_W-1:0]   pwdata,
    input logic [trt_pkg::CFG_DATA_W-1:0]   prdata,
    input logic                             pready
);

    // A stalled result holds its value
    `TRT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result changed while stalled")

    // Input backpressure only comes from a stalled output
    `TRT_ASSERT(a_in_stall, !in_ready |-> (out_valid && !out_ready), "input stalled without output stall")

    // A lane time stays zero until it is captured
    `TRT_ASSERT(a_lane_clear, out_valid |-> ((out_data.left_finished || (out_data.left_lane_time == '0)) && (out_data.right_finished || (out_data.right_lane_time == '0))), "lane time set without finish flag")

    // A read right after a write returns the written lane swap bit
    `TRT_ASSERT(a_cfg_readback, (psel && penable && pwrite && !paddr[2]) |=> (!(psel && !pwrite && !paddr[2]) || (prdata[0] == $past(pwdata[0]))), "lane swap readback mismatch")

    // Port never waits and reads only the defined bit
    `TRT_ASSERT_ALWAYS(a_cfg_port, pready && (prdata[trt_pkg::CFG_DATA_W-1:1] == '0), "config port misbehaves")

endmodule

bind two_lane_split_race_timer_core trt_checker u_trt_checker (.*);

// ===== sim/race_status_check.sv =====
// ----------------------------------------------------------------------------
// Race timer status checker
// Watches the sample, status and register channels, predicts each status item
// and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module race_status_check #(
    parameter int TIME_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  trt_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  trt_pkg::out_item_t             out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [trt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [trt_pkg::CFG_DATA_W-1:0] pwdata,
    output int                             mismatches,
    output int                             pending
);

    // Predicted timer state
    logic                 lane_swap;
    logic                 running;
    logic [TIME_BITS-1:0] race_time;
    logic [TIME_BITS-1:0] left_cap;
    logic [TIME_BITS-1:0] right_cap;
    logic                 left_done;
    logic                 right_done;
    logic [1:0]           armed;
    logic [2:0]           prev_btn;
    logic [1:0]           prev_tgt;

    trt_pkg::out_item_t status_q[$];

    function automatic void mark_finish(input logic right_lane);
        if (right_lane)
        begin
            right_cap  = race_time;
            right_done = 1'b1;
        end
        else
        begin
            left_cap  = race_time;
            left_done = 1'b1;
        end
    endfunction

    function automatic trt_pkg::out_item_t predict_status(input trt_pkg::in_item_t s);
        logic [2:0]         btn;
        logic [2:0]         watch;
        logic [2:0]         rise;
        logic [1:0]         tgt;
        logic [1:0]         fall;
        trt_pkg::out_item_t r;
        btn   = {s.reset_level, s.stop_level, s.start_level};
        tgt   = {s.target_one_level, s.target_zero_level};
        watch = running ? trt_pkg::BTN_STOP : (trt_pkg::BTN_START | trt_pkg::BTN_RESET);
        rise  = btn & ~prev_btn & watch;
        fall  = prev_tgt & ~tgt;

        if (rise == trt_pkg::BTN_START)
            running = 1'b1;
        else if (rise == trt_pkg::BTN_STOP)
            running = 1'b0;
        else if (rise == trt_pkg::BTN_RESET && tgt == trt_pkg::TGT_BOTH)
        begin
            armed      = trt_pkg::TGT_BOTH;
            race_time  = '0;
            left_cap   = '0;
            right_cap  = '0;
            left_done  = 1'b0;
            right_done = 1'b0;
            running    = 1'b0;
        end

        // Target zero goes first; a stop it causes blocks target one
        if (running && fall[0] && armed[0])
        begin
            armed = armed & ~trt_pkg::TGT_ZERO;
            mark_finish(lane_swap);
            if (armed == trt_pkg::TGT_NONE)
                running = 1'b0;
        end
        if (running && fall[1] && armed[1])
        begin
            armed = armed & ~trt_pkg::TGT_ONE;
            mark_finish(!lane_swap);
            if (armed == trt_pkg::TGT_NONE)
                running = 1'b0;
        end

        if (running && s.tick)
            race_time = race_time + TIME_BITS'(1);

        prev_btn = btn;
        prev_tgt = tgt;

        r.is_running      = running;
        r.elapsed         = trt_pkg::OUT_TIME_W'(race_time);
        r.left_lane_time  = trt_pkg::OUT_TIME_W'(left_cap);
        r.right_lane_time = trt_pkg::OUT_TIME_W'(right_cap);
        r.left_finished   = left_done;
        r.right_finished  = right_done;
        return r;
    endfunction

    function automatic void check_field(input string fname,
                                        input logic [trt_pkg::OUT_TIME_W-1:0] want,
                                        input logic [trt_pkg::OUT_TIME_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 50)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, fname, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_swap  = trt_pkg::LANE_SWAP_RESET;
            running    = 1'b0;
            race_time  = '0;
            left_cap   = '0;
            right_cap  = '0;
            left_done  = 1'b0;
            right_done = 1'b0;
            armed      = trt_pkg::TGT_BOTH;
            prev_btn   = trt_pkg::BTN_NONE;
            prev_tgt   = trt_pkg::TGT_BOTH;
            mismatches = 0;
            status_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[2] == trt_pkg::CFG_IDX_LANE_SWAP)
                lane_swap = pwdata[0];

            if (in_valid && in_ready)
                status_q.push_back(predict_status(in_data));

            if (out_valid && out_ready)
            begin
                if (status_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: status item with none expected, got elapsed %0d",
                             $time, out_data.elapsed);
                end
                else
                begin
                    trt_pkg::out_item_t want;
                    want = status_q.pop_front();
                    check_field("is_running",
                                trt_pkg::OUT_TIME_W'(want.is_running),
                                trt_pkg::OUT_TIME_W'(out_data.is_running));
                    check_field("elapsed", want.elapsed, out_data.elapsed);
                    check_field("left_lane_time", want.left_lane_time,
                                out_data.left_lane_time);
                    check_field("right_lane_time", want.right_lane_time,
                                out_data.right_lane_time);
                    check_field("left_finished",
                                trt_pkg::OUT_TIME_W'(want.left_finished),
                                trt_pkg::OUT_TIME_W'(out_data.left_finished));
                    check_field("right_finished",
                                trt_pkg::OUT_TIME_W'(want.right_finished),
                                trt_pkg::OUT_TIME_W'(out_data.right_finished));
                end
            end
        end
        pending = status_q.size();
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Race timer regression bench
// Drives pin samples and lane_swap writes into the race timer core through
// four traffic phases; a side checker predicts and compares every status item.
// ----------------------------------------------------------------------------
module tb;

    // A narrow timer checks that times are zero-extended onto the 32-bit outputs
    localparam int RACE_TIME_BITS = 16;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int PHASE_ITEMS    = 200;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    trt_pkg::in_item_t              in_data;
    logic                           out_valid;
    logic                           out_ready;
    trt_pkg::out_item_t             out_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [trt_pkg::CFG_ADDR_W-1:0] paddr;
    logic [trt_pkg::CFG_DATA_W-1:0] pwdata;
    logic [trt_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    int mismatches;
    int pending;

    // Traffic shape of the current phase, in percent
    int idle_pct;
    int stall_pct;
    int phase_items;
    int cycles;

    // Current pin levels, so a race can move one pin at a time
    logic lv_start;
    logic lv_stop;
    logic lv_reset;
    logic lv_t0;
    logic lv_t1;

    two_lane_split_race_timer_core #(
        .TIME_BITS (RACE_TIME_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    race_status_check #(
        .TIME_BITS (RACE_TIME_BITS)
    ) status_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the status side at random each cycle, at the phase's rate
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Give up once the cycle budget is spent
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("two_lane_split_race_timer_core regression: fail");
        $finish;
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // Offer one item: idle first at the phase's rate, then hold valid and the
    // payload until the core takes it. Entered and left at a falling edge.
    task automatic push_sample(input trt_pkg::in_item_t s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Set the pin levels and send them as one item
    task automatic send_pins(input logic tk, input logic st, input logic sp,
                             input logic rs, input logic z, input logic o);
        trt_pkg::in_item_t s;
        lv_start            = st;
        lv_stop             = sp;
        lv_reset            = rs;
        lv_t0               = z;
        lv_t1               = o;
        s.tick              = tk;
        s.start_level       = st;
        s.stop_level        = sp;
        s.reset_level       = rs;
        s.target_zero_level = z;
        s.target_one_level  = o;
        phase_items++;
        push_sample(s);
    endtask

    // Two-phase register write; pready is tied high, so no wait states
    task automatic cfg_write(input logic [trt_pkg::CFG_ADDR_W-1:0] a,
                             input logic [trt_pkg::CFG_DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One well-formed race: release all, clear, start, then let targets fall
    // and buttons move at random with random ticks in between
    task automatic run_race();
        int len;
        int r;
        send_pins(rand_bit(), 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(rand_bit(), 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_pins(rand_bit(), 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(rand_bit(), 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        len = $urandom_range(4, 30);
        repeat (len)
        begin
            r = $urandom_range(99);
            if (r < 12)
                lv_t0 = ~lv_t0;
            else if (r < 24)
                lv_t1 = ~lv_t1;
            else if (r < 29)
                lv_stop = ~lv_stop;
            else if (r < 34)
                lv_start = ~lv_start;
            else if (r < 37)
                lv_reset = ~lv_reset;
            send_pins(rand_bit(), lv_start, lv_stop, lv_reset, lv_t0, lv_t1);
        end
    endtask

    // Fixed opening: the corner cases of the button and target logic
    task automatic run_directed();
        send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);  // quiet
        send_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);  // tick while stopped
        send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);  // target falls while stopped
        send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);  // clear with a target low
        send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);  // start and clear together
        send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);  // start, tick counts
        send_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);  // target zero hit
        send_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // last target, tick dropped
        send_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);  // start with nothing armed
        send_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // falls on disarmed targets
        send_pins(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);  // stop; clear not watched
        send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);  // clear
        send_pins(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);  // start, clear held
        send_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // both targets fall together
        send_pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_pins(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);  // clear
        send_pins(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);  // start
        send_pins(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);  // stop while start held
    endtask

    initial
    begin
        int idle_tbl[4];
        int stall_tbl[4];
        logic swap_tbl[4];
        idle_tbl  = '{0, 68, 0, 15};
        stall_tbl = '{0, 0, 68, 15};
        swap_tbl  = '{1'b1, 1'b0, 1'b1, 1'b0};

        // Drive every input to a known value before the first edge
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        idle_pct  = 0;
        stall_pct = 0;
        lv_start  = 1'b0;
        lv_stop   = 1'b0;
        lv_reset  = 1'b0;
        lv_t0     = 1'b1;
        lv_t1     = 1'b1;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            // The core is drained here, so the swap setting may change
            cfg_write({trt_pkg::CFG_IDX_LANE_SWAP, 2'b00},
                      trt_pkg::CFG_DATA_W'(swap_tbl[ph]));
            idle_pct  = idle_tbl[ph];
            stall_pct = stall_tbl[ph];

            if (ph == 0)
            begin
                run_directed();
            end

            // Mostly well-formed races, with bursts of raw pin noise between
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 75)
                    run_race();
                else
                    repeat ($urandom_range(3, 12))
                        send_pins(rand_bit(), rand_bit(), rand_bit(),
                                  rand_bit(), rand_bit(), rand_bit());
            end

            // Drop valid and drain before the next register write
            in_valid <= 1'b0;
            wait (pending == 0);
            repeat (4) @(negedge clk);
        end

        // Allow any stray status item to show up before the verdict
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("two_lane_split_race_timer_core regression: pass");
        else
            $display("two_lane_split_race_timer_core regression: fail");
        $finish;
    end

endmodule
